@@ rtl/core/smtk_pkg.sv @@
// ----------------------------------------------------------------------------
// smtk_pkg: shared types and constants of the softmax top-k head
// Exponential tables, widths and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package smtk_pkg;

    localparam int MAX_CLASSES_DEF = 1024;
    localparam int MAX_TOP_K_DEF   = 8;
    localparam int LOGIT_W         = 16;
    localparam int PROB_W          = 16;
    localparam int INDEX_W         = 10;
    localparam int TOPK_W          = 4;
    localparam int SUM_W           = 27;
    localparam logic [TOPK_W-1:0] TOPK_RESET = 4'd5;

    // exp(-i) in Q1.16, i = 0..11
    function automatic logic [16:0] exp_int(input logic [3:0] i);
        logic [16:0] r;
        case (i)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // exp(-h/16) in Q1.16
    function automatic logic [16:0] exp_high(input logic [3:0] h);
        logic [16:0] r;
        case (h)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25665;
        endcase
        return r;
    endfunction

    // exp(-l/256) in Q1.16
    function automatic logic [16:0] exp_low(input logic [3:0] l);
        logic [16:0] r;
        case (l)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd65280;
            4'd2:    r = 17'd65026;
            4'd3:    r = 17'd64772;
            4'd4:    r = 17'd64520;
            4'd5:    r = 17'd64268;
            4'd6:    r = 17'd64018;
            4'd7:    r = 17'd63768;
            4'd8:    r = 17'd63520;
            4'd9:    r = 17'd63272;
            4'd10:   r = 17'd63025;
            4'd11:   r = 17'd62780;
            4'd12:   r = 17'd62535;
            4'd13:   r = 17'd62291;
            4'd14:   r = 17'd62048;
            default: r = 17'd61806;
        endcase
        return r;
    endfunction

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store logit, update max
        logic clear_vec;  // clear count, max, sum
        logic sum_start;  // begin the exp/sum pass
        logic prob_start; // begin the probability/insert pass
        logic emit_start; // begin reporting
    } smtk_cmd_t;

    // status from the datapath
    typedef struct packed {
        logic sum_done;
        logic prob_done;
        logic emit_done;
    } smtk_sts_t;

endpackage

@@ rtl/core/smtk_div.sv @@
// ----------------------------------------------------------------------------
// smtk_div: restoring divider
// Computes (num) / den one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module smtk_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 27
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    // one quotient bit a cycle
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = trial - {1'b0, den};
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

@@ rtl/core/smtk_datapath.sv @@
// ----------------------------------------------------------------------------
// smtk_datapath: logit store, exponential, sum, divide and top-k list
// Sequenced by commands from the controller, reports completion in status.
// ----------------------------------------------------------------------------
module smtk_datapath #(
    parameter int MAX_CLASSES = smtk_pkg::MAX_CLASSES_DEF,
    parameter int MAX_TOP_K   = smtk_pkg::MAX_TOP_K_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smtk_pkg::smtk_cmd_t                 cmd,
    output smtk_pkg::smtk_sts_t                 sts,
    input  logic signed [smtk_pkg::LOGIT_W-1:0] logit,
    input  logic [smtk_pkg::TOPK_W-1:0]         top_k,
    output logic                                res_valid,
    output logic [smtk_pkg::INDEX_W-1:0]        res_index,
    output logic [smtk_pkg::PROB_W-1:0]         res_prob,
    output logic                                res_last
);

    localparam int ADDR_W = $clog2(MAX_CLASSES);
    localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int K_W    = $clog2(MAX_TOP_K + 1);
    // room for MAX_CLASSES values of up to 65536 each
    localparam int SUM_W  = $clog2(MAX_CLASSES) + 17;
    localparam int NUM_W  = 17 + 16;
    localparam int IDX_W  = smtk_pkg::INDEX_W;

    // logit memory
    logic [smtk_pkg::LOGIT_W-1:0] mem [MAX_CLASSES];
    logic [smtk_pkg::LOGIT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]            rd_addr;

    logic [CNT_W-1:0]             count_reg;
    logic signed [15:0]           max_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [K_W-1:0]               kk_reg;

    // pass sequencing
    typedef enum logic [2:0] {
        P_IDLE, P_READ, P_E1, P_E2, P_E3, P_DIV, P_INS
    } pass_t;
    pass_t            pass_reg;
    logic             prob_pass_reg;
    logic [CNT_W-1:0] ptr_reg;

    // exponential pipeline
    logic [15:0] d_reg;
    logic [16:0] e_reg;
    logic        zero_reg;
    logic [15:0] d_w;
    logic [33:0] prod_w;

    // divider
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [NUM_W-1:0] div_num;
    logic             div_busy_seen;
    logic [15:0]      p_reg;

    // top-k list
    logic [IDX_W-1:0] bidx_reg [MAX_TOP_K];
    logic [15:0]      bval_reg [MAX_TOP_K];
    logic [K_W-1:0]   n_reg;
    logic [K_W-1:0]   pos_w;

    // emitter
    logic             emit_reg;
    logic [K_W-1:0]   eptr_reg;
    logic             rv_reg, rl_reg;
    logic [IDX_W-1:0] ri_reg;
    logic [15:0]      rp_reg;
    logic             sum_done_reg, prob_done_reg, emit_done_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < CNT_W'(MAX_CLASSES))
        begin
            mem[count_reg[ADDR_W-1:0]] <= logit;
        end
        rd_data_reg <= mem[rd_addr];
    end
    assign rd_addr = ptr_reg[ADDR_W-1:0];

    // exponential stage inputs
    assign d_w    = 16'(max_reg - $signed(rd_data_reg));
    assign prod_w = (pass_reg == P_E2) ? e_reg * smtk_pkg::exp_high(d_reg[7:4])
                                       : e_reg * smtk_pkg::exp_low(d_reg[3:0]);
    assign div_num   = {e_reg[16:0], 16'd0} + NUM_W'(sum_reg >> 1);
    assign div_start = (pass_reg == P_DIV) && !div_busy_seen;

    smtk_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (sum_reg),
        .done (div_done),
        .quot (div_quot)
    );

    // insertion position: entries with value >= p stay ahead
    always_comb
    begin
        pos_w = '0;
        for (int j = 0; j < MAX_TOP_K; j++)
        begin
            if (K_W'(j) < n_reg && bval_reg[j] >= p_reg)
            begin
                pos_w = K_W'(j + 1);
            end
        end
    end

    // control of vector state and passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            max_reg       <= 16'sh8000;
            sum_reg       <= '0;
            pass_reg      <= P_IDLE;
            prob_pass_reg <= 1'b0;
            ptr_reg       <= '0;
            n_reg         <= '0;
            kk_reg        <= '0;
            div_busy_seen <= 1'b0;
            d_reg         <= '0;
            e_reg         <= '0;
            zero_reg      <= 1'b0;
            p_reg         <= '0;
            emit_reg      <= 1'b0;
            eptr_reg      <= '0;
            rv_reg        <= 1'b0;
            rl_reg        <= 1'b0;
            ri_reg        <= '0;
            rp_reg        <= '0;
            sum_done_reg  <= 1'b0;
            prob_done_reg <= 1'b0;
            emit_done_reg <= 1'b0;
            for (int j = 0; j < MAX_TOP_K; j++)
            begin
                bidx_reg[j] <= '0;
                bval_reg[j] <= '0;
            end
        end
        else
        begin
            // completion pulses and result strobe
            sum_done_reg  <= (cmd.sum_start && count_reg == '0) ||
                             (pass_reg == P_E3 && !prob_pass_reg &&
                              ptr_reg + 1'b1 == count_reg);
            prob_done_reg <= (cmd.prob_start && (count_reg == '0 || sum_reg == '0)) ||
                             (pass_reg == P_INS && ptr_reg + 1'b1 == count_reg);
            emit_done_reg <= (cmd.emit_start && n_reg == '0) ||
                             (!cmd.emit_start && emit_reg && eptr_reg + 1'b1 == n_reg);
            rv_reg        <= !cmd.emit_start && emit_reg;
            if (cmd.clear_vec)
            begin
                count_reg <= '0;
                max_reg   <= 16'sh8000;
                sum_reg   <= '0;
            end
            else if (cmd.load && count_reg < CNT_W'(MAX_CLASSES))
            begin
                count_reg <= count_reg + 1'b1;
                if (logit > max_reg)
                begin
                    max_reg <= logit;
                end
            end
            if (cmd.sum_start || cmd.prob_start)
            begin
                prob_pass_reg <= cmd.prob_start;
                ptr_reg       <= '0;
                n_reg         <= '0;
                if (cmd.sum_start)
                begin
                    sum_reg <= '0;
                    if (top_k == '0)
                        kk_reg <= K_W'(1);
                    else if ({28'd0, top_k} > 32'(MAX_TOP_K))
                        kk_reg <= K_W'(MAX_TOP_K);
                    else
                        kk_reg <= K_W'(top_k);
                end
                else if (32'(kk_reg) > 32'(count_reg))
                begin
                    kk_reg <= K_W'(count_reg);
                end
                if (count_reg != '0 && !(cmd.prob_start && sum_reg == '0))
                begin
                    pass_reg <= P_READ;
                end
            end
            case (pass_reg)
                P_READ:
                begin
                    pass_reg <= P_E1;
                end
                P_E1:
                begin
                    d_reg    <= d_w;
                    zero_reg <= (d_w[15:8] >= 8'd12);
                    e_reg    <= smtk_pkg::exp_int(d_w[11:8]);
                    pass_reg <= P_E2;
                end
                P_E2:
                begin
                    e_reg    <= 17'((prod_w + 34'd32768) >> 16);
                    pass_reg <= P_E3;
                end
                P_E3:
                begin
                    e_reg <= zero_reg ? 17'd0 : 17'((prod_w + 34'd32768) >> 16);
                    if (prob_pass_reg)
                    begin
                        pass_reg <= P_DIV;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + SUM_W'(zero_reg ? 34'd0
                                                   : ((prod_w + 34'd32768) >> 16));
                        ptr_reg <= ptr_reg + 1'b1;
                        if (ptr_reg + 1'b1 == count_reg)
                        begin
                            pass_reg <= P_IDLE;
                        end
                        else
                        begin
                            pass_reg <= P_READ;
                        end
                    end
                end
                P_DIV:
                begin
                    if (div_done)
                    begin
                        div_busy_seen <= 1'b0;
                        p_reg    <= (div_quot > NUM_W'(65535)) ? 16'hFFFF : div_quot[15:0];
                        pass_reg <= P_INS;
                    end
                    else
                    begin
                        div_busy_seen <= 1'b1;
                    end
                end
                P_INS:
                begin
                    // shift lower entries down and insert
                    if (pos_w < kk_reg)
                    begin
                        for (int j = MAX_TOP_K - 1; j > 0; j--)
                        begin
                            if (K_W'(j) > pos_w && K_W'(j) < kk_reg)
                            begin
                                bval_reg[j] <= bval_reg[j-1];
                                bidx_reg[j] <= bidx_reg[j-1];
                            end
                        end
                        bval_reg[pos_w[$clog2(MAX_TOP_K > 1 ? MAX_TOP_K : 2)-1:0]]
                            <= p_reg;
                        bidx_reg[pos_w[$clog2(MAX_TOP_K > 1 ? MAX_TOP_K : 2)-1:0]]
                            <= IDX_W'(ptr_reg);
                        if (n_reg < kk_reg) n_reg <= n_reg + 1'b1;
                    end
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg + 1'b1 == count_reg)
                    begin
                        pass_reg <= P_IDLE;
                    end
                    else
                    begin
                        pass_reg <= P_READ;
                    end
                end
                default:
                begin
                end
            endcase
            // report
            if (cmd.emit_start)
            begin
                eptr_reg <= '0;
                if (n_reg != '0) emit_reg <= 1'b1;
            end
            else if (emit_reg)
            begin
                ri_reg   <= bidx_reg[eptr_reg[$clog2(MAX_TOP_K > 1 ? MAX_TOP_K : 2)-1:0]];
                rp_reg   <= bval_reg[eptr_reg[$clog2(MAX_TOP_K > 1 ? MAX_TOP_K : 2)-1:0]];
                rl_reg   <= (eptr_reg + 1'b1 == n_reg);
                eptr_reg <= eptr_reg + 1'b1;
                if (eptr_reg + 1'b1 == n_reg)
                begin
                    emit_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.sum_done  = sum_done_reg;
    assign sts.prob_done = prob_done_reg;
    assign sts.emit_done = emit_done_reg;
    assign res_valid     = rv_reg;
    assign res_index     = ri_reg;
    assign res_prob      = rp_reg;
    assign res_last      = rl_reg;

endmodule

@@ rtl/core/smtk_ctrl.sv @@
// ----------------------------------------------------------------------------
// smtk_ctrl: controller of the softmax top-k head
// Loads logits, then runs sum, probability and report passes in turn.
// ----------------------------------------------------------------------------
module smtk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last_logit,
    input  smtk_pkg::smtk_sts_t sts,
    output smtk_pkg::smtk_cmd_t cmd,
    output logic                busy
);

    typedef enum logic [2:0] {
        S_LOAD, S_SUM_GO, S_SUM, S_PROB, S_EMIT, S_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load = 1'b1;
                    if (last_logit) state_next = S_SUM_GO;
                end
            end
            S_SUM_GO:
            begin
                cmd.sum_start = 1'b1;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                if (sts.sum_done)
                begin
                    cmd.prob_start = 1'b1;
                    state_next     = S_PROB;
                end
            end
            S_PROB:
            begin
                if (sts.prob_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.emit_done) state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.clear_vec = 1'b1;
                state_next    = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_LOAD);
        end
    end

    assign busy = busy_reg;

endmodule

@@ rtl/core/softmax_top_k_select_unit.sv @@
// ----------------------------------------------------------------------------
// softmax_top_k_select_unit: softmax classifier head with top-k report
// Stores a vector of Q8.8 logits and reports the best classes by probability.
// ----------------------------------------------------------------------------
// usage
//   a logit transfer happens at a clock edge with start high and busy low;
//   logits load one per cycle while busy stays low
//   the logit marked last_logit raises busy; the block then runs
//     a sum pass (memory read, three table/multiply steps per class), a
//     probability pass that repeats these steps per class with a
//     bit-serial divide and a top-k insertion added, and a report of one
//     result per cycle
//   each result shows on class_index/probability/last_result for one cycle
//   with result_valid high; the receiver cannot stall the report
//   top_k is written through top_k_we/top_k_data only while busy is low, by
//   the user (unenforced); reset clears the vector and sets top_k to 5; the
//   logit memory needs no clearing pass since only written entries are read
// ----------------------------------------------------------------------------
module softmax_top_k_select_unit #(
    parameter int MAX_CLASSES = smtk_pkg::MAX_CLASSES_DEF,
    parameter int MAX_TOP_K   = smtk_pkg::MAX_TOP_K_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [smtk_pkg::LOGIT_W-1:0] logit,
    input  logic                                last_logit,
    input  logic                                top_k_we,
    input  logic [smtk_pkg::TOPK_W-1:0]         top_k_data,
    output logic                                result_valid,
    output logic [smtk_pkg::INDEX_W-1:0]        class_index,
    output logic [smtk_pkg::PROB_W-1:0]         probability,
    output logic                                last_result
);

    smtk_pkg::smtk_cmd_t         cmd;
    smtk_pkg::smtk_sts_t         sts;
    logic [smtk_pkg::TOPK_W-1:0] top_k_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_k_reg <= smtk_pkg::TOPK_RESET;
        else if (top_k_we)
            top_k_reg <= top_k_data;
    end

    smtk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_logit(last_logit),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    smtk_datapath #(.MAX_CLASSES(MAX_CLASSES), .MAX_TOP_K(MAX_TOP_K)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .logit    (logit),
        .top_k    (top_k_reg),
        .res_valid(result_valid),
        .res_index(class_index),
        .res_prob (probability),
        .res_last (last_result)
    );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for softmax_top_k_select_unit
// Drives logit vectors and top_k settings from a queue of pending transfers,
// predicts each top-k report in the bench and checks every reported class.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STORE_DEPTH = smtk_pkg::MAX_CLASSES_DEF;
    localparam int  REPORT_MAX  = smtk_pkg::MAX_TOP_K_DEF;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int  SETTLE_CYCLES  = 40;

    localparam int unsigned EXP_INT_TAB[12] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
    };
    localparam int unsigned EXP_HIGH_TAB[16] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
        39750, 37341, 35079, 32954, 30957, 29081, 27319, 25665
    };
    localparam int unsigned EXP_LOW_TAB[16] = '{
        65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
        63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806
    };

    typedef enum logic [1:0] {
        ACT_LOGIT,
        ACT_TOPK,
        ACT_DRAIN,
        ACT_IDLE_RATE
    } action_kind_t;

    typedef struct {
        action_kind_t       act;
        logic signed [15:0] value;
        logic               last;
    } action_t;

    typedef struct {
        logic [smtk_pkg::INDEX_W-1:0] index;
        logic [smtk_pkg::PROB_W-1:0]  prob;
        logic                         last;
    } report_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic signed [smtk_pkg::LOGIT_W-1:0] logit;
    logic                                last_logit;
    logic                                top_k_we;
    logic [smtk_pkg::TOPK_W-1:0]         top_k_data;
    logic                                result_valid;
    logic [smtk_pkg::INDEX_W-1:0]        class_index;
    logic [smtk_pkg::PROB_W-1:0]         probability;
    logic                                last_result;

    action_t                     pending_q[$];
    report_t                     report_q[$];
    logic signed [15:0]          vector_logits[$];
    int                          vector_max;
    logic [smtk_pkg::TOPK_W-1:0] shadow_top_k;
    int                          sender_idle_pct;
    int                          settle_count;
    int                          error_count;
    int                          logits_sent;
    int                          vectors_done;
    int                          reports_seen;
    longint                      cycle_count;

    softmax_top_k_select_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .logit        (logit),
        .last_logit   (last_logit),
        .top_k_we     (top_k_we),
        .top_k_data   (top_k_data),
        .result_valid (result_valid),
        .class_index  (class_index),
        .probability  (probability),
        .last_result  (last_result)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // table exponential of (max - v), Q1.16
    function automatic longint exp_of_gap(int mx, int v);
        int unsigned gap;
        longint      e;
        gap = (mx - v) & 16'hFFFF;
        if ((gap >> 8) >= 12)
            return 0;
        e = EXP_INT_TAB[gap >> 8];
        e = (e * EXP_HIGH_TAB[(gap >> 4) & 15] + 32768) >> 16;
        e = (e * EXP_LOW_TAB[gap & 15] + 32768) >> 16;
        return e;
    endfunction

    // store one accepted logit, and on the last one work out the report
    task automatic take_logit(logic signed [15:0] v, logic is_last);
        longint  sum;
        longint  prob[];
        bit      taken[];
        int      count;
        int      k;
        int      best;
        report_t rep;
        if (vector_logits.size() < STORE_DEPTH)
        begin
            vector_logits.insert(vector_logits.size(), v);
            if (int'(v) > vector_max)
                vector_max = v;
        end
        if (!is_last)
            return;
        count = vector_logits.size();
        k = (shadow_top_k == 0) ? 1 : int'(shadow_top_k);
        if (k > REPORT_MAX)
            k = REPORT_MAX;
        if (k > count)
            k = count;
        sum = 0;
        foreach (vector_logits[c])
            sum += exp_of_gap(vector_max, vector_logits[c]);
        prob = new[count];
        taken = new[count];
        foreach (vector_logits[c])
        begin
            prob[c] = (exp_of_gap(vector_max, vector_logits[c]) * 65536 + sum / 2) / sum;
            if (prob[c] > 65535)
                prob[c] = 65535;
        end
        // highest first, equal values keep the lower index first
        for (int r = 0; r < k; r++)
        begin
            best = -1;
            for (int c = 0; c < count; c++)
                if (!taken[c] && (best < 0 || prob[c] > prob[best]))
                    best = c;
            taken[best] = 1'b1;
            rep.index = best[smtk_pkg::INDEX_W-1:0];
            rep.prob  = prob[best][smtk_pkg::PROB_W-1:0];
            rep.last  = (r == k - 1);
            report_q.insert(report_q.size(), rep);
        end
        vector_logits.delete();
        vector_max = -32768;
        vectors_done++;
    endtask

    // driver: logit transfers, top_k writes, drains and idle-rate changes
    always @(posedge clk or negedge rst_n)
    begin
        logic    next_start;
        logic    next_we;
        action_t a;
        if (!rst_n)
        begin
            start      <= 1'b0;
            logit      <= '0;
            last_logit <= 1'b0;
            top_k_we   <= 1'b0;
            top_k_data <= '0;
        end
        else
        begin
            next_start = start;
            next_we    = 1'b0;
            if (start && !busy)
            begin
                take_logit(logit, last_logit);
                logits_sent++;
                next_start = 1'b0;
            end
            if (!next_start && pending_q.size() > 0)
            begin
                a = pending_q[0];
                case (a.act)
                    ACT_IDLE_RATE:
                    begin
                        sender_idle_pct = a.value;
                        void'(pending_q.pop_front());
                    end
                    ACT_DRAIN:
                    begin
                        if (report_q.size() == 0 && !busy && !start)
                            settle_count++;
                        else
                            settle_count = 0;
                        if (settle_count >= SETTLE_CYCLES)
                        begin
                            settle_count = 0;
                            void'(pending_q.pop_front());
                        end
                    end
                    ACT_TOPK:
                    begin
                        next_we = 1'b1;
                        top_k_data <= a.value[smtk_pkg::TOPK_W-1:0];
                        shadow_top_k = a.value[smtk_pkg::TOPK_W-1:0];
                        void'(pending_q.pop_front());
                    end
                    default:
                    begin
                        if ($urandom_range(99) >= sender_idle_pct)
                        begin
                            next_start = 1'b1;
                            logit      <= a.value;
                            last_logit <= a.last;
                            void'(pending_q.pop_front());
                        end
                    end
                endcase
            end
            start    <= next_start;
            top_k_we <= next_we;
        end
    end

    // monitor: each reported class against the oldest prediction
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && result_valid)
        begin
            reports_seen++;
            if (report_q.size() == 0)
            begin
                $error("unexpected result: class_index %0d probability %0d",
                       class_index, probability);
                error_count++;
            end
            else
            begin
                want = report_q.pop_front();
                if (class_index !== want.index)
                begin
                    $error("class_index: expected %0d, got %0d", want.index, class_index);
                    error_count++;
                end
                if (probability !== want.prob)
                begin
                    $error("probability: expected %0d, got %0d", want.prob, probability);
                    error_count++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last, last_result);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_action(action_kind_t act, int value, logic is_last);
        action_t a;
        a.act   = act;
        a.value = value[15:0];
        a.last  = is_last;
        pending_q.insert(pending_q.size(), a);
    endtask

    // drain, then write top_k
    task automatic add_top_k(int value);
        add_action(ACT_DRAIN, 0, 1'b0);
        add_action(ACT_TOPK, value, 1'b0);
    endtask

    // random vector, values clustered near a base so several classes matter
    task automatic add_random_vector(int length);
        int base;
        int v;
        base = $urandom_range(65535) - 32768;
        for (int i = 0; i < length; i++)
        begin
            case ($urandom_range(3))
                0:       v = $urandom_range(65535) - 32768;
                1:       v = base;
                default: v = base - $urandom_range(1200) + $urandom_range(300);
            endcase
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            add_action(ACT_LOGIT, v, i == length - 1);
        end
    endtask

    initial
    begin
        int target;
        int phase_rates[4];
        int added;
        int len;
        rst_n           = 1'b0;
        cycle_count     = 0;
        error_count     = 0;
        logits_sent     = 0;
        vectors_done    = 0;
        reports_seen    = 0;
        settle_count    = 0;
        sender_idle_pct = 0;
        vector_max      = -32768;
        shadow_top_k    = smtk_pkg::TOPK_RESET;
        phase_rates     = '{0, 76, 0, 31};

        // directed: extremes, ties, single class, top_k clamps
        add_action(ACT_LOGIT, 32767, 1'b0);
        add_action(ACT_LOGIT, -32768, 1'b0);
        add_action(ACT_LOGIT, 0, 1'b0);
        add_action(ACT_LOGIT, 32767, 1'b0);
        add_action(ACT_LOGIT, 32767 - 256, 1'b0);
        add_action(ACT_LOGIT, 32767 - 3072, 1'b1);
        add_top_k(8);
        add_action(ACT_LOGIT, -32768, 1'b1);
        add_action(ACT_LOGIT, 100, 1'b0);
        add_action(ACT_LOGIT, -21555, 1'b0);
        add_action(ACT_LOGIT, 100, 1'b0);
        add_action(ACT_LOGIT, 100, 1'b1);
        add_top_k(0);
        add_action(ACT_LOGIT, 5, 1'b0);
        add_action(ACT_LOGIT, 5, 1'b1);
        add_top_k(15);
        add_random_vector(10);
        add_top_k(1);
        add_random_vector(4);

        // random phases at several sender idle rates
        foreach (phase_rates[p])
        begin
            add_action(ACT_DRAIN, 0, 1'b0);
            add_action(ACT_IDLE_RATE, phase_rates[p], 1'b0);
            target = 62;
            added = 0;
            while (added < target)
            begin
                if ($urandom_range(3) == 0)
                    add_top_k($urandom_range(15));
                len = $urandom_range(12, 1);
                add_random_vector(len);
                added += len;
            end
        end
        add_top_k(8);
        add_random_vector(9);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !start);
        wait (report_q.size() == 0);
        repeat (100) @(posedge clk);

        $display("%0d logits in %0d vectors sent, %0d reported classes checked",
                 logits_sent, vectors_done, reports_seen);
        $display("top_k swept from 0 to 15, ties, extreme logits and sender idling covered");
        if (error_count == 0 && report_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/smtk_pkg.sv
rtl/core/smtk_div.sv
rtl/core/smtk_datapath.sv
rtl/core/smtk_ctrl.sv
rtl/core/softmax_top_k_select_unit.sv
test/testbench.sv
